### src/pstl_pkg.sv
`default_nettype none

package pstl_pkg;

   localparam int SLOT_COUNT   = 16;
   localparam int KEY_BITS     = 64;
   localparam int PEER_ID_BITS = 16;
   localparam int TIME_BITS    = 32;

   localparam int IDX_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int AGE_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

   typedef logic [IDX_BITS-1:0]     idx_type;
   typedef logic [KEY_BITS-1:0]     key_type;
   typedef logic [PEER_ID_BITS-1:0] peer_type;
   typedef logic [TIME_BITS-1:0]    time_type;
   typedef logic [AGE_BITS-1:0]     age_type;

   localparam idx_type IDX_LAST = idx_type'(SLOT_COUNT - 1);

   // command codes
   localparam logic [2:0] CMD_ADD    = 3'd0;
   localparam logic [2:0] CMD_REMOVE = 3'd1;
   localparam logic [2:0] CMD_PICK   = 3'd2;
   localparam logic [2:0] CMD_TOUCH  = 3'd3;
   localparam logic [2:0] CMD_FIND   = 3'd4;
   localparam logic [2:0] CMD_AGED   = 3'd5;

   localparam logic [4:0] AGED_MAX = 5'd31;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] peer_id;
      logic [63:0] peer_key;
      logic        replace_dup;
      logic [31:0] now_time;
      logic [3:0]  start_index;
      logic [31:0] min_age;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [3:0]  slot_index;
      logic        evicted_valid;
      logic [15:0] evicted_peer;
      logic [4:0]  aged_count;
   } rsp_type;

   // one slot as read out of the table
   typedef struct packed {
      logic     valid;
      peer_type peer;
      key_type  key;
      time_type since;
      time_type activity;
   } slot_type;

   typedef enum logic [1:0] {
      WR_FILL,
      WR_TOUCH,
      WR_CLEAR
   } wr_op_type;

   typedef struct packed {
      logic      en;
      wr_op_type op;
      idx_type   idx;
      peer_type  peer;
      key_type   key;
      time_type  now;
   } wr_type;

   // per-slot compare results
   typedef struct packed {
      logic key_eq;
      logic peer_eq;
      logic act_less;
      logic aged;
   } eval_type;

endpackage

`default_nettype wire

### src/pstl_slot_store.sv
`default_nettype none

module pstl_slot_store (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pstl_pkg::idx_type  rd_idx,
   input  wire pstl_pkg::wr_type   wr,
   output pstl_pkg::slot_type      rd_data
);

   logic [pstl_pkg::SLOT_COUNT-1:0] valid_ff;
   pstl_pkg::peer_type peer_ff     [pstl_pkg::SLOT_COUNT];
   pstl_pkg::key_type  key_ff      [pstl_pkg::SLOT_COUNT];
   pstl_pkg::time_type since_ff    [pstl_pkg::SLOT_COUNT];
   pstl_pkg::time_type activity_ff [pstl_pkg::SLOT_COUNT];
   pstl_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         unique case (wr.op)
            pstl_pkg::WR_FILL:  valid_ff[wr.idx] <= 1'b1;
            pstl_pkg::WR_CLEAR: valid_ff[wr.idx] <= 1'b0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.op == pstl_pkg::WR_FILL) begin
         peer_ff[wr.idx]     <= wr.peer;
         key_ff[wr.idx]      <= wr.key;
         since_ff[wr.idx]    <= wr.now;
         activity_ff[wr.idx] <= wr.now;
      end else if (wr.en && wr.op == pstl_pkg::WR_TOUCH) begin
         activity_ff[wr.idx] <= wr.now;
      end
      rd_data_ff.valid    <= valid_ff[rd_idx];
      rd_data_ff.peer     <= peer_ff[rd_idx];
      rd_data_ff.key      <= key_ff[rd_idx];
      rd_data_ff.since    <= since_ff[rd_idx];
      rd_data_ff.activity <= activity_ff[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/pstl_slot_eval.sv
`default_nettype none

module pstl_slot_eval (
   input  wire pstl_pkg::req_type   req,
   input  wire pstl_pkg::slot_type  slot,
   input  wire pstl_pkg::time_type  lru_act,
   output pstl_pkg::eval_type       result
);

   pstl_pkg::time_type now;
   pstl_pkg::time_type age;

   // a start time in the future counts as age zero
   assign now = pstl_pkg::time_type'(req.now_time);
   assign age = (now >= slot.since) ? (now - slot.since) : '0;

   assign result.key_eq   = (slot.key == pstl_pkg::key_type'(req.peer_key));
   assign result.peer_eq  = (slot.peer == pstl_pkg::peer_type'(req.peer_id));
   assign result.act_less = (slot.activity < lru_act);
   assign result.aged     = (pstl_pkg::age_type'(age) > pstl_pkg::age_type'(req.min_age));

endmodule

`default_nettype wire

### src/pstl_scan_seq.sv
`default_nettype none

module pstl_scan_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire pstl_pkg::req_type  req_data,
   input  wire logic               out_free,
   output logic                    done,
   output pstl_pkg::rsp_type       rsp,
   output pstl_pkg::idx_type       rd_idx,
   input  wire pstl_pkg::slot_type rd_data,
   output pstl_pkg::wr_type        wr
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      proc_en_ff;
   logic      key_hit_ff, empty_hit_ff, peer_hit_ff, pick_hit_ff;

   pstl_pkg::req_type  req_ff;
   pstl_pkg::idx_type  cnt_ff, pos_ff, proc_idx_ff;
   pstl_pkg::idx_type  key_idx_ff, empty_idx_ff, lru_idx_ff, peer_idx_ff, pick_idx_ff;
   pstl_pkg::peer_type key_peer_ff, lru_peer_ff;
   pstl_pkg::time_type lru_act_ff;
   logic [4:0]         aged_ff;

   pstl_pkg::eval_type ev;
   pstl_pkg::idx_type  start_pos, first_pos;
   logic               accept, replace_hit;
   pstl_pkg::idx_type  add_idx;
   pstl_pkg::peer_type add_peer;

   pstl_slot_eval u_eval (
      .req     (req_ff),
      .slot    (rd_data),
      .lru_act (lru_act_ff),
      .result  (ev)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rd_idx    = pos_ff;

   // pick begins one slot after the start offset
   assign start_pos = pstl_pkg::idx_type'(req_data.start_index % pstl_pkg::SLOT_COUNT);
   assign first_pos = (req_data.command != pstl_pkg::CMD_PICK) ? '0 :
                      (start_pos == pstl_pkg::IDX_LAST) ? '0 : start_pos + 1'b1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_SCAN;
         ST_SCAN:   if (cnt_ff == pstl_pkg::IDX_LAST) state_in = ST_FLUSH;
         ST_FLUSH:  state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         proc_en_ff   <= 1'b0;
         key_hit_ff   <= 1'b0;
         empty_hit_ff <= 1'b0;
         peer_hit_ff  <= 1'b0;
         pick_hit_ff  <= 1'b0;
         aged_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         proc_en_ff <= (state_ff == ST_SCAN);
         if (accept) begin
            key_hit_ff   <= 1'b0;
            empty_hit_ff <= 1'b0;
            peer_hit_ff  <= 1'b0;
            pick_hit_ff  <= 1'b0;
            aged_ff      <= '0;
         end else if (proc_en_ff) begin
            if (rd_data.valid && ev.key_eq) key_hit_ff <= 1'b1;
            if (!rd_data.valid) empty_hit_ff <= 1'b1;
            if (rd_data.valid && ev.peer_eq) peer_hit_ff <= 1'b1;
            if (rd_data.valid) pick_hit_ff <= 1'b1;
            if (rd_data.valid && ev.aged && aged_ff != pstl_pkg::AGED_MAX) begin
               aged_ff <= aged_ff + 1'b1;
            end
         end
      end
   end

   // scan pointers and captured slot data
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
         cnt_ff <= '0;
         pos_ff <= first_pos;
      end else if (state_ff == ST_SCAN) begin
         cnt_ff <= cnt_ff + 1'b1;
         pos_ff <= (pos_ff == pstl_pkg::IDX_LAST) ? '0 : pos_ff + 1'b1;
      end
      proc_idx_ff <= pos_ff;
      if (proc_en_ff) begin
         if (rd_data.valid && ev.key_eq && !key_hit_ff) begin
            key_idx_ff  <= proc_idx_ff;
            key_peer_ff <= rd_data.peer;
         end
         if (!rd_data.valid && !empty_hit_ff) empty_idx_ff <= proc_idx_ff;
         if (rd_data.valid && ev.peer_eq && !peer_hit_ff) peer_idx_ff <= proc_idx_ff;
         if (rd_data.valid && !pick_hit_ff) pick_idx_ff <= proc_idx_ff;
         // least activity, first slot on ties
         if (proc_idx_ff == '0 || ev.act_less) begin
            lru_idx_ff  <= proc_idx_ff;
            lru_act_ff  <= rd_data.activity;
            lru_peer_ff <= rd_data.peer;
         end
      end
   end

   assign replace_hit = req_ff.replace_dup && key_hit_ff;
   assign add_idx     = replace_hit ? key_idx_ff : empty_hit_ff ? empty_idx_ff : lru_idx_ff;
   assign add_peer    = replace_hit ? key_peer_ff : lru_peer_ff;

   always_comb begin
      done    = (state_ff == ST_FINISH) && out_free;
      rsp     = '0;
      rsp.status = 1'b1;
      wr      = '0;
      wr.op   = pstl_pkg::WR_FILL;
      wr.idx  = add_idx;
      wr.peer = pstl_pkg::peer_type'(req_ff.peer_id);
      wr.key  = pstl_pkg::key_type'(req_ff.peer_key);
      wr.now  = pstl_pkg::time_type'(req_ff.now_time);
      unique case (req_ff.command)
         pstl_pkg::CMD_ADD: begin
            rsp.status        = 1'b0;
            rsp.slot_index    = 4'(add_idx);
            rsp.evicted_valid = replace_hit || !empty_hit_ff;
            rsp.evicted_peer  = (replace_hit || !empty_hit_ff) ? 16'(add_peer) : '0;
            wr.en             = done;
         end
         pstl_pkg::CMD_REMOVE, pstl_pkg::CMD_TOUCH: begin
            rsp.status     = !peer_hit_ff;
            rsp.slot_index = peer_hit_ff ? 4'(peer_idx_ff) : '0;
            wr.en          = done && peer_hit_ff;
            wr.idx         = peer_idx_ff;
            wr.op          = (req_ff.command == pstl_pkg::CMD_REMOVE) ?
                             pstl_pkg::WR_CLEAR : pstl_pkg::WR_TOUCH;
         end
         pstl_pkg::CMD_PICK: begin
            rsp.status     = !pick_hit_ff;
            rsp.slot_index = pick_hit_ff ? 4'(pick_idx_ff) : '0;
         end
         pstl_pkg::CMD_FIND: begin
            rsp.status = !key_hit_ff;
         end
         pstl_pkg::CMD_AGED: begin
            rsp.status     = 1'b0;
            rsp.aged_count = aged_ff;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

### src/peer_slot_table_lru_unit.sv
`default_nettype none

// Timing: from request transaction to response valid the sequencer reads each
// of the 16 slots in turn, drains the last read in a flush step, then finishes.
// A new transaction is taken only in the idle state that follows the finish step;
// the finish step holds while the response waits.
// Reset: synchronous, active high; empties every slot and drops any response.
module peer_slot_table_lru_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pstl_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pstl_pkg::rsp_type      rsp_data
);

   logic               rsp_valid_ff;
   pstl_pkg::rsp_type  rsp_data_ff;

   logic               out_free;
   logic               seq_done;
   pstl_pkg::rsp_type  seq_rsp;
   pstl_pkg::idx_type  rd_idx;
   pstl_pkg::slot_type rd_data;
   pstl_pkg::wr_type   wr;

   // Slot table: valid bits in flops, payload in arrays, one registered read
   // port walked by the sequencer and one write port used at the end.
   pstl_slot_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (rd_idx),
      .wr      (wr),
      .rd_data (rd_data)
   );

   // Scan sequencer: one slot compared per cycle, first-hit and LRU trackers
   // updated in order, the write-back and response formed in the finish step.
   pstl_scan_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_free  (out_free),
      .done      (seq_done),
      .rsp       (seq_rsp),
      .rd_idx    (rd_idx),
      .rd_data   (rd_data),
      .wr        (wr)
   );

   // Response register: the sequencer may take the next transaction while
   // the previous response waits; it only holds its finish step when full and not taken.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_done) begin
         rsp_data_ff <= seq_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // busy for the whole scan once a transaction is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a scan is in progress");

   // never overwrite a response that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      seq_done |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before transfer");

   // an eviction only comes from a successful add
   a_evict_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.evicted_valid |->
         rsp_data_ff.status == 1'b0 && rsp_data_ff.aged_count == 5'd0)
      else $error("eviction reported on a non-add response");

endmodule

`default_nettype wire
